// ----- design/msmm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msmm_pkg - shared types and helpers
// Beat layouts, saturation limits, lane count limits and lane field pickers
// for the masked vector accumulate unit.
// ----------------------------------------------------------------------------
package msmm_pkg;

    localparam int CARRIED_LANES = 4;
    localparam int DEFAULT_LANES = 4;
    localparam int DATA_W        = 16;
    localparam int ACC_W         = 32;
    localparam int POOL_SHIFT    = 12;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 32'sh8000_0000;

    typedef enum logic {
        FUNC_MAC  = 1'b0,
        FUNC_POOL = 1'b1
    } t_func;

    typedef struct packed {
        t_func                    func;
        logic [3:0]               lane_mask;
        logic signed [DATA_W-1:0] weight_0;
        logic signed [DATA_W-1:0] weight_1;
        logic signed [DATA_W-1:0] weight_2;
        logic signed [DATA_W-1:0] weight_3;
        logic signed [DATA_W-1:0] sample_0;
        logic signed [DATA_W-1:0] sample_1;
        logic signed [DATA_W-1:0] sample_2;
        logic signed [DATA_W-1:0] sample_3;
        logic                     last_item;
    } t_in_beat;

    typedef struct packed {
        logic signed [ACC_W-1:0] accumulated;
    } t_out_beat;

    typedef struct packed {
        logic signed [ACC_W-1:0] initial_accumulator;
    } t_cfg_beat;

    // control handed from the lane stage to the accumulator stage
    typedef struct packed {
        logic  fire;
        t_func func;
        logic  last;
    } t_acc_ctl;

    function automatic logic signed [DATA_W-1:0] get_weight(input t_in_beat b,
                                                            input logic [1:0] idx);
        logic signed [DATA_W-1:0] w;
        case (idx)
            2'd0:    w = b.weight_0;
            2'd1:    w = b.weight_1;
            2'd2:    w = b.weight_2;
            default: w = b.weight_3;
        endcase
        return w;
    endfunction

    function automatic logic signed [DATA_W-1:0] get_sample(input t_in_beat b,
                                                            input logic [1:0] idx);
        logic signed [DATA_W-1:0] d;
        case (idx)
            2'd0:    d = b.sample_0;
            2'd1:    d = b.sample_1;
            2'd2:    d = b.sample_2;
            default: d = b.sample_3;
        endcase
        return d;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0]   s;
        logic signed [ACC_W-1:0] r;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            r = s[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            r = s[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- design/msmm_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msmm_stream_if - valid/ready channel
// One beat moves on a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface msmm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/msmm_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msmm_lane - one vector lane
// Registers the lane product and the widened pooling value of one beat.
// ----------------------------------------------------------------------------
module msmm_lane (
    input  logic                                 i_clk,
    input  logic                                 i_load,
    input  logic                                 i_en,
    input  logic signed [msmm_pkg::DATA_W-1:0]   i_weight,
    input  logic signed [msmm_pkg::DATA_W-1:0]   i_sample,
    output logic                                 o_en,
    output logic signed [msmm_pkg::ACC_W-1:0]    o_product,
    output logic signed [msmm_pkg::ACC_W-1:0]    o_widened
);
    import msmm_pkg::*;

    logic                    r_en;
    logic signed [ACC_W-1:0] r_product;
    logic signed [ACC_W-1:0] r_widened;
    logic signed [ACC_W-1:0] n_product;
    logic signed [ACC_W-1:0] n_widened;

    always_comb begin
        // 16x16 signed product always fits 32 bits
        n_product = i_weight * i_sample;
        n_widened = {{(ACC_W-DATA_W-POOL_SHIFT){i_sample[DATA_W-1]}},
                     i_sample, {POOL_SHIFT{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_en      <= i_en;
            r_product <= n_product;
            r_widened <= n_widened;
        end
    end

    assign o_en      = r_en;
    assign o_product = r_product;
    assign o_widened = r_widened;

endmodule

// ----- design/msmm_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msmm_merge - accumulator and result register
// Folds the lane results into the run accumulator in lane order and holds
// the finished value until the result beat is taken.
// ----------------------------------------------------------------------------
module msmm_merge #(
    parameter int LANES = msmm_pkg::DEFAULT_LANES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  msmm_pkg::t_acc_ctl                 i_ctl,
    input  logic [LANES-1:0]                   i_en,
    input  logic signed [msmm_pkg::ACC_W-1:0]  i_product [LANES],
    input  logic signed [msmm_pkg::ACC_W-1:0]  i_widened [LANES],
    input  logic signed [msmm_pkg::ACC_W-1:0]  i_init,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic signed [msmm_pkg::ACC_W-1:0]  o_acc
);
    import msmm_pkg::*;

    logic signed [ACC_W-1:0] r_acc;
    logic                    r_run_open;
    logic                    r_out_valid;
    logic signed [ACC_W-1:0] r_out_acc;
    logic signed [ACC_W-1:0] n_acc;

    // lane order matters for MAC: each add saturates before the next
    always_comb begin
        n_acc = r_run_open ? r_acc : i_init;
        for (int k = 0; k < LANES; k++) begin
            if (i_en[k]) begin
                if (i_ctl.func == FUNC_MAC) begin
                    n_acc = sat_add(n_acc, i_product[k]);
                end else if (n_acc < i_widened[k]) begin
                    n_acc = i_widened[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_run_open  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.fire) begin
                r_run_open <= !i_ctl.last;
                if (!i_ctl.last) begin
                    r_acc <= n_acc;
                end
            end
            if (i_ctl.fire && i_ctl.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fire && i_ctl.last) begin
            r_out_acc <= n_acc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_acc       = r_out_acc;

endmodule

// ----- design/masked_simd_mac_maxpool_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_simd_mac_maxpool_top - masked vector accumulate unit
// Lane-parallel multiply-accumulate / max-pool over runs of vector beats.
// ----------------------------------------------------------------------------
// Usage
//   i_in  : input beats (func, lane_mask, four weights, four samples,
//           last_item). Each beat carries one vector; one beat per cycle unless stalled.
//   o_out : one result beat (accumulated) per run, after the beat marked last.
//   i_cfg : writes initial_accumulator; always ready. Write only while the
//           unit is idle; the value is picked up at the start of each run.
// Timing
//   Throughput: one input beat per cycle unless a last beat waits on an
//   untaken result, including across run boundaries. The accumulator loop
//   (up to four saturating adds or compares in lane order) is combinational.
//   Result path: the last beat of a run is captured in the lane register
//   when accepted, then the result register loads the run's result.
// Reset
//   Synchronous, active low. Clears initial_accumulator, the accumulator, the
//   open-run flag and all valid flags; the next beat starts a new run.
// Backpressure
//   A finished result waits in the result register while further beats of
//   the next run keep flowing. Input stalls only when a second last beat
//   waits in the lane stage while the first result is still not taken.
// ----------------------------------------------------------------------------
module masked_simd_mac_maxpool_top #(
    parameter int LANES = msmm_pkg::DEFAULT_LANES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    msmm_stream_if.sink   i_in,
    msmm_stream_if.source o_out,
    msmm_stream_if.sink   i_cfg
);
    import msmm_pkg::*;

    // lanes beyond the four carried in a beat do nothing
    localparam int ACT_LANES = (LANES < CARRIED_LANES) ? LANES : CARRIED_LANES;

    t_in_beat in_beat;
    t_cfg_beat cfg_beat;

    logic                    in_fire;
    logic                    s1_fire;
    logic                    out_free;
    logic                    out_valid;
    logic signed [ACC_W-1:0] out_acc;

    logic                    r_s1_valid;
    t_func                   r_s1_func;
    logic                    r_s1_last;
    logic signed [ACC_W-1:0] r_init;

    logic [ACT_LANES-1:0]    lane_en;
    logic signed [ACC_W-1:0] lane_product [ACT_LANES];
    logic signed [ACC_W-1:0] lane_widened [ACT_LANES];

    t_acc_ctl acc_ctl;

    assign in_beat  = i_in.data;
    assign cfg_beat = i_cfg.data;

    // configuration: single register, taken every cycle
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
        end else if (i_cfg.valid) begin
            r_init <= cfg_beat.initial_accumulator;
        end
    end

    // flow control: lane stage drains unless it holds a last beat and the
    // result register is still occupied and not being taken
    assign out_free    = !out_valid || o_out.ready;
    assign s1_fire     = r_s1_valid && (!r_s1_last || out_free);
    assign i_in.ready  = !r_s1_valid || s1_fire;
    assign in_fire     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_func <= in_beat.func;
            r_s1_last <= in_beat.last_item;
        end
    end

    for (genvar k = 0; k < ACT_LANES; k++) begin : g_lane
        msmm_lane u_lane (
            .i_clk     (i_clk),
            .i_load    (in_fire),
            .i_en      (in_beat.lane_mask[k]),
            .i_weight  (get_weight(in_beat, 2'(k))),
            .i_sample  (get_sample(in_beat, 2'(k))),
            .o_en      (lane_en[k]),
            .o_product (lane_product[k]),
            .o_widened (lane_widened[k])
        );
    end

    always_comb begin
        acc_ctl.fire = s1_fire;
        acc_ctl.func = r_s1_func;
        acc_ctl.last = r_s1_last;
    end

    msmm_merge #(
        .LANES (ACT_LANES)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (acc_ctl),
        .i_en        (lane_en),
        .i_product   (lane_product),
        .i_widened   (lane_widened),
        .i_init      (r_init),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_acc       (out_acc)
    );

    assign o_out.valid            = out_valid;
    assign o_out.data.accumulated = out_acc;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_result_from_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_valid) |-> $past(s1_fire && r_s1_last))
        else $error("result beat raised without a last beat reaching the accumulator");

    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !o_out.ready |-> !(s1_fire && r_s1_last))
        else $error("pending result overwritten");

    a_stall_blocks_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_last && out_valid && !o_out.ready |-> !i_in.ready)
        else $error("input accepted while lane stage is blocked");

    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid && !r_s1_valid)
        else $error("valid flags not cleared by reset");

endmodule
